// File: rtl/ttpi_pkg.sv
package ttpi_pkg;

    localparam int CHANNELS         = 4;
    localparam int THRUST_W         = 17;
    localparam int DUTY_W           = 10;
    localparam int TABLE_SLOTS      = 16;
    localparam int SEG_W            = $clog2(TABLE_SLOTS);
    localparam int CURVE_POINTS_DEF = 8;

    // Offset inside the widest segment (11141 steps) and reciprocal format.
    localparam int OFF_W       = 14;
    localparam int RECIP_SHIFT = 27;
    localparam int RECIP_W     = 25;
    localparam int PROD_W      = OFF_W + RECIP_W;

    typedef logic signed [THRUST_W-1:0] t_thrust;
    typedef logic        [DUTY_W-1:0]   t_duty;

    // Curve breakpoints: thrust in Q1.16 newtons, PWM counts.
    localparam longint CT0 = 0;
    localparam longint CT1 = 11141;
    localparam longint CT2 = 16384;
    localparam longint CT3 = 19005;
    localparam longint CT4 = 20972;
    localparam longint CT5 = 22282;
    localparam longint CT6 = 22938;
    localparam longint CT7 = 23593;

    localparam longint CP0 = 310;
    localparam longint CP1 = 420;
    localparam longint CP2 = 520;
    localparam longint CP3 = 620;
    localparam longint CP4 = 720;
    localparam longint CP5 = 820;
    localparam longint CP6 = 920;
    localparam longint CP7 = 1020;

    localparam t_thrust CURVE_THRUST [TABLE_SLOTS] = '{
        THRUST_W'(CT0), THRUST_W'(CT1), THRUST_W'(CT2), THRUST_W'(CT3),
        THRUST_W'(CT4), THRUST_W'(CT5), THRUST_W'(CT6), THRUST_W'(CT7),
        '0, '0, '0, '0, '0, '0, '0, '0
    };

    localparam t_duty CURVE_PWM [TABLE_SLOTS] = '{
        DUTY_W'(CP0), DUTY_W'(CP1), DUTY_W'(CP2), DUTY_W'(CP3),
        DUTY_W'(CP4), DUTY_W'(CP5), DUTY_W'(CP6), DUTY_W'(CP7),
        '0, '0, '0, '0, '0, '0, '0, '0
    };

    // Per segment (indexed by its upper point): ceil(pwm_span * 2^S / thrust_span).
    // With span^2 <= 2^S, (off * recip) >> S equals floor(pwm_span * off / span)
    // for every off in [0, span]. Segments that can never match hold zero.
    localparam logic [RECIP_W-1:0] SEG_RECIP [TABLE_SLOTS] = '{
        '0,
        RECIP_W'((((CP1 - CP0) << RECIP_SHIFT) + (CT1 - CT0) - 1) / (CT1 - CT0)),
        RECIP_W'((((CP2 - CP1) << RECIP_SHIFT) + (CT2 - CT1) - 1) / (CT2 - CT1)),
        RECIP_W'((((CP3 - CP2) << RECIP_SHIFT) + (CT3 - CT2) - 1) / (CT3 - CT2)),
        RECIP_W'((((CP4 - CP3) << RECIP_SHIFT) + (CT4 - CT3) - 1) / (CT4 - CT3)),
        RECIP_W'((((CP5 - CP4) << RECIP_SHIFT) + (CT5 - CT4) - 1) / (CT5 - CT4)),
        RECIP_W'((((CP6 - CP5) << RECIP_SHIFT) + (CT6 - CT5) - 1) / (CT6 - CT5)),
        RECIP_W'((((CP7 - CP6) << RECIP_SHIFT) + (CT7 - CT6) - 1) / (CT7 - CT6)),
        '0, '0, '0, '0, '0, '0, '0, '0
    };

endpackage

// File: rtl/ttpi_if.sv
interface ttpi_thrust_if import ttpi_pkg::*; ();
    logic    valid;
    logic    ready;
    t_thrust thrust_a;
    t_thrust thrust_b;
    t_thrust thrust_c;
    t_thrust thrust_d;

    modport source (output valid, output thrust_a, output thrust_b,
                    output thrust_c, output thrust_d, input ready);
    modport sink   (input valid, input thrust_a, input thrust_b,
                    input thrust_c, input thrust_d, output ready);
endinterface

interface ttpi_duty_if import ttpi_pkg::*; ();
    logic  valid;
    logic  ready;
    t_duty duty_a;
    t_duty duty_b;
    t_duty duty_c;
    t_duty duty_d;

    modport source (output valid, output duty_a, output duty_b,
                    output duty_c, output duty_d, input ready);
    modport sink   (input valid, input duty_a, input duty_b,
                    input duty_c, input duty_d, output ready);
endinterface

// File: rtl/thrust_to_pwm_interpolator.sv
// Four-channel thrust-to-PWM converter by piecewise linear interpolation.
// Input channel i_thrust carries four signed Q1.16 thrusts per item; output
// channel o_duty carries the four 10-bit PWM duties. Both are valid/ready;
// an item moves at a clock edge with valid and ready high.
// Each item gives exactly one result item, in order.
// Path: an accepted item goes into the input register, then through one
// compute pass into the result register.
// Throughput: one item per cycle unless o_duty stalls; each channel does one
// table search, one 14x25 reciprocal multiply and one add per pass.
// Zero thrust gives duty 0. A thrust that no curve segment brackets
// (negative or above the top breakpoint) repeats the channel's last duty.
// Reset (i_rst_n low, synchronous) empties both stages and clears the held
// duties to zero.
// When the receiver stalls, the result register holds its item, one more
// item waits in the input register, and i_thrust.ready drops until o_duty
// is taken.
module thrust_to_pwm_interpolator import ttpi_pkg::*; #(
    parameter int CURVE_POINTS = CURVE_POINTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ttpi_thrust_if.sink   i_thrust,
    ttpi_duty_if.source   o_duty
);

    // Input stage: one registered item.
    logic    r_in_vld;
    t_thrust r_thr [CHANNELS];

    // Result stage: the duties are also the held per-channel state.
    logic    r_out_vld;
    t_duty   r_duty [CHANNELS];
    t_duty   n_duty [CHANNELS];

    logic    advance;
    logic    in_ready;

    // Map one thrust to a duty; prev is the channel's last duty.
    function automatic t_duty f_interp(t_thrust t, t_duty prev);
        logic                      hit;
        logic [SEG_W-1:0]          seg;
        logic [SEG_W-1:0]          lo_idx;
        logic signed [THRUST_W:0]  off_full;
        logic [OFF_W-1:0]          off;
        logic [PROD_W-1:0]         prod;
        t_duty                     res;
        hit = 1'b0;
        seg = '0;
        // Scan from the top so the lowest bracketing segment wins.
        for (int k = CURVE_POINTS - 1; k >= 1; k--) begin
            if (CURVE_THRUST[k-1] <= t && CURVE_THRUST[k] >= t) begin
                hit = 1'b1;
                seg = SEG_W'(k);
            end
        end
        lo_idx   = seg - SEG_W'(1);
        off_full = (THRUST_W+1)'(t) - (THRUST_W+1)'(CURVE_THRUST[lo_idx]);
        off      = off_full[OFF_W-1:0];
        prod     = PROD_W'(off) * PROD_W'(SEG_RECIP[seg]);
        res      = CURVE_PWM[lo_idx] + prod[RECIP_SHIFT +: DUTY_W];
        if (t == '0) begin
            return '0;
        end else if (hit) begin
            return res;
        end else begin
            return prev;
        end
    endfunction

    // Advance when the result register is empty or being drained.
    assign advance  = r_in_vld && (!r_out_vld || o_duty.ready);
    assign in_ready = !r_in_vld || advance;
    assign i_thrust.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_ready) begin
            r_in_vld <= i_thrust.valid;
        end
    end

    // Capture the payload on accept; no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_ready && i_thrust.valid) begin
            r_thr[0] <= i_thrust.thrust_a;
            r_thr[1] <= i_thrust.thrust_b;
            r_thr[2] <= i_thrust.thrust_c;
            r_thr[3] <= i_thrust.thrust_d;
        end
    end

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            n_duty[i] = f_interp(r_thr[i], r_duty[i]);
        end
    end

    // The result register doubles as the held duty, so it is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_duty[i] <= '0;
            end
        end else begin
            if (advance) begin
                r_out_vld <= 1'b1;
                for (int i = 0; i < CHANNELS; i++) begin
                    r_duty[i] <= n_duty[i];
                end
            end else if (o_duty.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_duty.valid  = r_out_vld;
    assign o_duty.duty_a = r_duty[0];
    assign o_duty.duty_b = r_duty[1];
    assign o_duty.duty_c = r_duty[2];
    assign o_duty.duty_d = r_duty[3];

    // A waiting item moves on whenever the result register can take it.
    a_moves_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && (!r_out_vld || o_duty.ready)) |=> r_out_vld)
        else $error("input item did not reach result register");

    // Held duties change only when an item passes.
    a_held_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_duty[0]) && $stable(r_duty[1]) &&
                      $stable(r_duty[2]) && $stable(r_duty[3])))
        else $error("held duty changed without an item");

    // Zero thrust on channel a forces duty zero.
    a_zero_thrust: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_thr[0] == '0) |=> (r_duty[0] == '0))
        else $error("zero thrust did not give zero duty");

    // Negative thrust on channel b repeats its last duty.
    a_negative_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_thr[1][THRUST_W-1]) |=> (r_duty[1] == $past(r_duty[1])))
        else $error("negative thrust did not hold duty");

    // No duty on channels c and d goes above the top of the curve.
    a_duty_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_duty[2] <= DUTY_W'(CP7) && r_duty[3] <= DUTY_W'(CP7)))
        else $error("duty above top breakpoint");

endmodule
